// ----- rtl/assert_macros.svh -----
// Assertion macros for the lock-in demodulator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

`endif

// ----- rtl/tsld_pkg.sv -----
// Shared types, constants and elaboration-time tables for the demodulator.
// No dependencies.
package tsld_pkg;

    localparam int BIN_W          = 8;
    localparam int BIN_COUNT      = 1 << BIN_W;
    localparam int SAMPLE_W       = 16;
    localparam int ACC_W          = 32;
    localparam int ANGLE_W_MAX    = 12;
    localparam int TABLE_SIZE_DEF = 256;
    localparam int MAX_PERIOD_DEF = 256;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Three-level reference value
    typedef enum logic [1:0] {
        REF_ZERO = 2'd0,
        REF_POS  = 2'd1,
        REF_NEG  = 2'd2
    } t_ref;

    // State update controls from the handshake logic
    typedef struct packed {
        logic fire;    // item leaves the input register this cycle
        logic clear;   // that item is a clear command
        logic cfg_we;  // bin register write
    } t_ctl;

    // bin modulo size, by repeated subtraction (elaboration only)
    function automatic logic [ANGLE_W_MAX-1:0] f_bin_step(int unsigned bin,
                                                          int unsigned size);
        int unsigned r;
        r = bin;
        for (int k = 0; k < BIN_COUNT; k++) begin
            if (r >= size) begin
                r = r - size;
            end
        end
        return r[ANGLE_W_MAX-1:0];
    endfunction

    // size / gcd(step, size) <= maxp, written as size <= maxp * gcd
    function automatic logic f_period_fits(int unsigned step, int unsigned size,
                                           int unsigned maxp);
        int unsigned a;
        int unsigned b;
        int unsigned g;
        a = step;
        b = size;
        for (int k = 0; k < 2 * (1 << ANGLE_W_MAX); k++) begin
            if (a != 0 && b != 0) begin
                if (a >= b) begin
                    a = a - b;
                end else begin
                    b = b - a;
                end
            end
        end
        g = a + b;
        return (g != 0) && (size <= maxp * g);
    endfunction

    function automatic logic [BIN_COUNT-1:0][ANGLE_W_MAX-1:0] f_step_table(
        int unsigned size);
        logic [BIN_COUNT-1:0][ANGLE_W_MAX-1:0] t;
        for (int b = 0; b < BIN_COUNT; b++) begin
            t[b] = f_bin_step(b, size);
        end
        return t;
    endfunction

    function automatic logic [BIN_COUNT-1:0] f_ok_table(int unsigned size,
                                                        int unsigned maxp);
        logic [BIN_COUNT-1:0] t;
        for (int b = 0; b < BIN_COUNT; b++) begin
            t[b] = f_period_fits(f_bin_step(b, size), size, maxp);
        end
        return t;
    endfunction

endpackage

// ----- rtl/tsld_ref.sv -----
// Square reference generator: sign(cos) and sign(-sin) of the angle index.
// Depends on tsld_pkg.
module tsld_ref #(
    parameter int TABLE_SIZE = tsld_pkg::TABLE_SIZE_DEF
) (
    input  logic [$clog2(TABLE_SIZE)-1:0] i_angle,
    output tsld_pkg::t_ref                o_ref_cos,
    output tsld_pkg::t_ref                o_ref_nsin
);

    localparam int AW = $clog2(TABLE_SIZE);

    localparam logic [AW+1:0] Q_N1 = (AW+2)'(TABLE_SIZE);
    localparam logic [AW+1:0] Q_N3 = (AW+2)'(3 * TABLE_SIZE);
    localparam logic [AW:0]   H_N  = (AW+1)'(TABLE_SIZE);

    logic [AW+1:0] quad;
    logic [AW:0]   half;

    assign quad = {i_angle, 2'b00};
    assign half = {i_angle, 1'b0};

    always_comb begin
        if (quad == Q_N1 || quad == Q_N3) begin
            o_ref_cos = tsld_pkg::REF_ZERO;
        end else if (quad < Q_N1 || quad > Q_N3) begin
            o_ref_cos = tsld_pkg::REF_POS;
        end else begin
            o_ref_cos = tsld_pkg::REF_NEG;
        end

        if (i_angle == '0 || half == H_N) begin
            o_ref_nsin = tsld_pkg::REF_ZERO;
        end else if (half < H_N) begin
            o_ref_nsin = tsld_pkg::REF_NEG;
        end else begin
            o_ref_nsin = tsld_pkg::REF_POS;
        end
    end

endmodule

// ----- rtl/tsld_state.sv -----
// Angle and accumulator state, bin-derived step and period flag.
// Depends on tsld_pkg and tsld_ref.
module tsld_state #(
    parameter int TABLE_SIZE = tsld_pkg::TABLE_SIZE_DEF,
    parameter int MAX_PERIOD = tsld_pkg::MAX_PERIOD_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tsld_pkg::t_ctl                      i_ctl,
    input  logic [tsld_pkg::BIN_W-1:0]          i_cfg_bin,
    input  logic signed [tsld_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [tsld_pkg::ACC_W-1:0]    o_sum_in_phase,
    output logic signed [tsld_pkg::ACC_W-1:0]    o_sum_quadrature,
    output logic                                o_period_ok
);

    localparam int AW = $clog2(TABLE_SIZE);

    localparam logic [tsld_pkg::BIN_COUNT-1:0][tsld_pkg::ANGLE_W_MAX-1:0] STEP_TAB =
        tsld_pkg::f_step_table(TABLE_SIZE);
    localparam logic [tsld_pkg::BIN_COUNT-1:0] OK_TAB =
        tsld_pkg::f_ok_table(TABLE_SIZE, MAX_PERIOD);
    localparam logic [tsld_pkg::BIN_W-1:0] BIN_RESET = tsld_pkg::BIN_W'(1);
    localparam logic [AW:0] TS_WIDE = (AW+1)'(TABLE_SIZE);

    logic [AW-1:0]                   r_angle;
    logic [AW-1:0]                   r_step;
    logic                            r_ok;
    logic signed [tsld_pkg::ACC_W-1:0] r_acc_i;
    logic signed [tsld_pkg::ACC_W-1:0] r_acc_q;

    logic [AW-1:0]                   n_angle;
    logic signed [tsld_pkg::ACC_W-1:0] n_acc_i;
    logic signed [tsld_pkg::ACC_W-1:0] n_acc_q;
    logic signed [tsld_pkg::ACC_W-1:0] upd_i;
    logic signed [tsld_pkg::ACC_W-1:0] upd_q;
    logic signed [tsld_pkg::ACC_W-1:0] x_ext;
    logic [AW:0]                     angle_sum;
    logic [AW-1:0]                   angle_adv;
    tsld_pkg::t_ref                  ref_cos;
    tsld_pkg::t_ref                  ref_nsin;

    tsld_ref #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_ref (
        .i_angle    (r_angle),
        .o_ref_cos  (ref_cos),
        .o_ref_nsin (ref_nsin)
    );

    assign x_ext = tsld_pkg::ACC_W'(i_sample);

    // angle + step < 2*TABLE_SIZE: one compare and subtract wraps it
    assign angle_sum = {1'b0, r_angle} + {1'b0, r_step};
    assign angle_adv = (angle_sum >= TS_WIDE) ? AW'(angle_sum - TS_WIDE)
                                              : angle_sum[AW-1:0];

    always_comb begin
        case (ref_cos)
            tsld_pkg::REF_POS: upd_i = r_acc_i + x_ext;
            tsld_pkg::REF_NEG: upd_i = r_acc_i - x_ext;
            default:           upd_i = r_acc_i;
        endcase
        case (ref_nsin)
            tsld_pkg::REF_POS: upd_q = r_acc_q + x_ext;
            tsld_pkg::REF_NEG: upd_q = r_acc_q - x_ext;
            default:           upd_q = r_acc_q;
        endcase

        if (i_ctl.clear) begin
            n_acc_i = '0;
            n_acc_q = '0;
            n_angle = '0;
        end else if (r_ok) begin
            n_acc_i = upd_i;
            n_acc_q = upd_q;
            n_angle = angle_adv;
        end else begin
            n_acc_i = r_acc_i;
            n_acc_q = r_acc_q;
            n_angle = r_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_acc_i <= '0;
            r_acc_q <= '0;
            r_step  <= STEP_TAB[BIN_RESET][AW-1:0];
            r_ok    <= OK_TAB[BIN_RESET];
        end else if (i_ctl.cfg_we) begin
            r_angle <= '0;
            r_acc_i <= '0;
            r_acc_q <= '0;
            r_step  <= STEP_TAB[i_cfg_bin][AW-1:0];
            r_ok    <= OK_TAB[i_cfg_bin];
        end else if (i_ctl.fire) begin
            r_angle <= n_angle;
            r_acc_i <= n_acc_i;
            r_acc_q <= n_acc_q;
        end
    end

    assign o_sum_in_phase   = n_acc_i;
    assign o_sum_quadrature = n_acc_q;
    assign o_period_ok      = r_ok;

endmodule

// ----- rtl/ternary_square_lockin_demodulator_unit.sv -----
// Top level of the ternary square-wave lock-in demodulator.
// Depends on tsld_pkg, tsld_state (with tsld_ref) and assert_macros.svh.

// Correlates a stream of signed 16-bit samples against three-level square
// references, sign(cos) for the in-phase sum and sign(-sin) for the
// quadrature sum, of an angle that advances by bin_index modulo TABLE_SIZE
// after each accumulated sample. Every input transaction yields exactly one
// result transaction: both 32-bit wrapping sums after that item and the
// period_ok flag. A clear command zeroes both sums and the angle. When the
// reference period TABLE_SIZE/gcd(bin, TABLE_SIZE) exceeds MAX_PERIOD the
// samples are ignored and the sums hold. Throughput is one item per clock
// while the result channel is not stalled: an item sits in the input
// register, its conditional add and subtract on each accumulator plus the
// angle step are computed there, and the result is registered into the
// output register as the item leaves. The bin register is written over
// its own channel, which is always ready; a write zeroes sums and angle and
// loads the angle step and period flag from constant per-bin tables. Write
// it only while no item is in flight. No clearing pass after reset.
module ternary_square_lockin_demodulator_unit #(
    parameter int TABLE_SIZE = tsld_pkg::TABLE_SIZE_DEF,
    parameter int MAX_PERIOD = tsld_pkg::MAX_PERIOD_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tsld_pkg::BIN_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_command,
    input  logic signed [tsld_pkg::SAMPLE_W-1:0] i_sample,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [tsld_pkg::ACC_W-1:0]    o_sum_in_phase,
    output logic signed [tsld_pkg::ACC_W-1:0]    o_sum_quadrature,
    output logic                                 o_period_ok
);

`include "assert_macros.svh"

    // input register
    logic                                 r_s1_valid;
    logic                                 r_s1_cmd;
    logic signed [tsld_pkg::SAMPLE_W-1:0] r_s1_sample;

    // result register
    logic                                 r_out_valid;
    logic signed [tsld_pkg::ACC_W-1:0]    r_sum_i;
    logic signed [tsld_pkg::ACC_W-1:0]    r_sum_q;
    logic                                 r_ok;

    logic                                 out_free;
    logic                                 s1_fire;
    tsld_pkg::t_ctl                       ctl;
    logic signed [tsld_pkg::ACC_W-1:0]    item_sum_i;
    logic signed [tsld_pkg::ACC_W-1:0]    item_sum_q;
    logic                                 item_ok;

    // result register can take a new item when empty or being drained
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign o_cfg_ready = 1'b1;

    assign ctl.fire   = s1_fire;
    assign ctl.clear  = (r_s1_cmd == tsld_pkg::CMD_CLEAR);
    assign ctl.cfg_we = i_cfg_valid;

    tsld_state #(
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_PERIOD (MAX_PERIOD)
    ) u_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_cfg_bin        (i_cfg_data),
        .i_sample         (r_s1_sample),
        .o_sum_in_phase   (item_sum_i),
        .o_sum_quadrature (item_sum_q),
        .o_period_ok      (item_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
        // payload, no reset
        if (i_in_valid && o_in_ready) begin
            r_s1_cmd    <= i_command;
            r_s1_sample <= i_sample;
        end
        if (s1_fire) begin
            r_sum_i <= item_sum_i;
            r_sum_q <= item_sum_q;
            r_ok    <= item_ok;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sum_in_phase   = r_sum_i;
    assign o_sum_quadrature = r_sum_q;
    assign o_period_ok      = r_ok;

    // an item leaving the input register always shows up as a result
    `ASSERT_NEXT(a_fire_to_out, i_clk, i_rst_n, s1_fire, r_out_valid)
    // a clear transaction reports zeroed sums
    `ASSERT_NEXT(a_clear_zero, i_clk, i_rst_n, s1_fire && ctl.clear,
                 r_sum_i == '0 && r_sum_q == '0)
    // input stalls only when both registers are full and the output is stalled
    `ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, !o_in_ready,
                 r_s1_valid && r_out_valid && !i_out_ready)

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for ternary_square_lockin_demodulator_unit.
// Depends on tsld_pkg and the demodulator RTL; predicts every result in place
// and compares it field by field against the DUT's result channel.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Block configuration; the predictor uses the same values.
    localparam int N_ANGLES       = tsld_pkg::TABLE_SIZE_DEF;
    localparam int MAX_REF_PERIOD = tsld_pkg::MAX_PERIOD_DEF;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    // Pipeline has an input and a result register; give it a little extra before a bin write.
    localparam int DRAIN_CYCLES  = 4;
    // Slowest legal run: about 1800 items, each seeing at most the longest
    // gap plus the longest stall that pick_gap can give.
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 175;
    // 65535 added to each sum per four samples, run back to back.
    localparam int WRAP_PERIODS  = 8;

    // One input transaction
    typedef struct {
        logic                                 cmd;
        logic signed [tsld_pkg::SAMPLE_W-1:0] sample;
    } t_demod_item;

    // One result transaction
    typedef struct {
        logic signed [tsld_pkg::ACC_W-1:0] sum_i;
        logic signed [tsld_pkg::ACC_W-1:0] sum_q;
        logic                              ok;
    } t_demod_result;

    //--------------------------------------------------------------------------
    // Clock, reset and DUT signals. Every input starts at a known value.
    //--------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    logic                                 cfg_valid = 1'b0;
    logic [tsld_pkg::BIN_W-1:0]           cfg_data  = '0;
    logic                                 cfg_ready;
    logic                                 drv_valid = 1'b0;
    logic                                 drv_cmd   = tsld_pkg::CMD_ACCUM;
    logic signed [tsld_pkg::SAMPLE_W-1:0] drv_sample = '0;
    logic                                 in_ready;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [tsld_pkg::ACC_W-1:0]    sum_in_phase;
    logic signed [tsld_pkg::ACC_W-1:0]    sum_quadrature;
    logic                                 period_ok;

    ternary_square_lockin_demodulator_unit #(
        .TABLE_SIZE (N_ANGLES),
        .MAX_PERIOD (MAX_REF_PERIOD)
    ) DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (drv_valid),
        .o_in_ready       (in_ready),
        .i_command        (drv_cmd),
        .i_sample         (drv_sample),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_sum_in_phase   (sum_in_phase),
        .o_sum_quadrature (sum_quadrature),
        .o_period_ok      (period_ok)
    );

    //--------------------------------------------------------------------------
    // Shared testbench state
    //--------------------------------------------------------------------------
    t_demod_item   pending_items[$];   // filled by the sequence, drained by driver
    t_demod_result expected_sums[$];   // predicted results, oldest first
    int            fail_count = 0;
    logic          idle_off   = 1'b0;  // back-to-back traffic on both sides
    logic          in_taken   = 1'b0;  // input transaction at the last rising edge
    int            gap_left   = 0;
    int            stall_left = 0;

    // Predictor copy of the block state
    logic [tsld_pkg::BIN_W-1:0]        bin_reg;
    int unsigned                       angle;
    logic signed [tsld_pkg::ACC_W-1:0] acc_i;
    logic signed [tsld_pkg::ACC_W-1:0] acc_q;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    //--------------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------------
    function automatic int unsigned gcd_of(int unsigned a, int unsigned b);
        int unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Reference period N/gcd(step, N) must not exceed the maximum
    function automatic logic period_fits(logic [tsld_pkg::BIN_W-1:0] bin);
        int unsigned g;
        g = gcd_of(int'(bin) % N_ANGLES, N_ANGLES);
        return (g != 0) && (N_ANGLES / g <= MAX_REF_PERIOD);
    endfunction

    // sign(cos): zero exactly at a quarter and three quarters of the table
    function automatic tsld_pkg::t_ref cos_sign(int unsigned a);
        int unsigned q;
        q = 4 * a;
        if (q == N_ANGLES || q == 3 * N_ANGLES) return tsld_pkg::REF_ZERO;
        if (q < N_ANGLES || q > 3 * N_ANGLES) return tsld_pkg::REF_POS;
        return tsld_pkg::REF_NEG;
    endfunction

    // sign(-sin): zero at angle 0 and at half the table
    function automatic tsld_pkg::t_ref nsin_sign(int unsigned a);
        if (a == 0 || 2 * a == N_ANGLES) return tsld_pkg::REF_ZERO;
        if (2 * a < N_ANGLES) return tsld_pkg::REF_NEG;
        return tsld_pkg::REF_POS;
    endfunction

    function automatic logic signed [tsld_pkg::ACC_W-1:0] steer(
        logic signed [tsld_pkg::ACC_W-1:0] acc,
        tsld_pkg::t_ref                    r,
        logic signed [tsld_pkg::ACC_W-1:0] x);
        case (r)
            tsld_pkg::REF_POS: return acc + x;
            tsld_pkg::REF_NEG: return acc - x;
            default:           return acc;
        endcase
    endfunction

    function automatic void clear_demod_state();
        angle = 0;
        acc_i = '0;
        acc_q = '0;
    endfunction

    function automatic t_demod_result demodulate(logic cmd,
                                                 logic signed [tsld_pkg::SAMPLE_W-1:0] x);
        t_demod_result                     r;
        logic signed [tsld_pkg::ACC_W-1:0] xs;
        logic                              ok;
        xs = x;  // sign extension
        ok = period_fits(bin_reg);
        if (cmd == tsld_pkg::CMD_CLEAR) begin
            clear_demod_state();
        end else if (ok) begin
            acc_i = steer(acc_i, cos_sign(angle), xs);
            acc_q = steer(acc_q, nsin_sign(angle), xs);
            angle = (angle + int'(bin_reg) % N_ANGLES) % N_ANGLES;
        end
        r.sum_i = acc_i;
        r.sum_q = acc_q;
        r.ok    = ok;
        return r;
    endfunction

    function automatic void check_field(string name, logic signed [tsld_pkg::ACC_W:0] expv,
                                        logic signed [tsld_pkg::ACC_W:0] actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            fail_count++;
        end
    endfunction

    //--------------------------------------------------------------------------
    // Input driver: changes at the falling edge. A held transaction stays put
    // until the monitor saw it accepted; then a gap, then the next item.
    //--------------------------------------------------------------------------
    always @(negedge clk) begin : drive_inputs
        t_demod_item nxt;
        if (!drv_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left  <= gap_left - 1;
                drv_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                nxt = pending_items.pop_front();
                drv_valid  <= 1'b1;
                drv_cmd    <= nxt.cmd;
                drv_sample <= nxt.sample;
                gap_left   <= idle_off ? 0 : pick_gap();
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure: random stalls of random length
    always @(negedge clk) begin : drive_result_ready
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            if (!idle_off && $urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap();
            end
        end
    end

    //--------------------------------------------------------------------------
    // Monitor: samples every channel at the rising edge. Bin writes and input
    // transactions update the predictor; result transactions are checked
    // against the oldest prediction.
    //--------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_demod_result exp_res;
        if (!rst_n) begin
            bin_reg = 8'd1;
            clear_demod_state();
        end else begin
            if (cfg_valid && cfg_ready) begin
                // A bin write restarts the reference at phase 0
                bin_reg = cfg_data;
                clear_demod_state();
            end
            if (out_valid && out_ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0b",
                             $time, sum_in_phase, sum_quadrature, period_ok);
                    fail_count++;
                end else begin
                    exp_res = expected_sums.pop_front();
                    check_field("sum_in_phase", exp_res.sum_i, sum_in_phase);
                    check_field("sum_quadrature", exp_res.sum_q, sum_quadrature);
                    check_field("period_ok", {tsld_pkg::ACC_W'(0), exp_res.ok},
                                {tsld_pkg::ACC_W'(0), period_ok});
                end
            end
            if (drv_valid && in_ready) begin
                expected_sums.push_back(demodulate(drv_cmd, drv_sample));
            end
        end
        in_taken <= rst_n && drv_valid && in_ready;
    end

    //--------------------------------------------------------------------------
    // Sequence helpers
    //--------------------------------------------------------------------------
    task automatic queue_item(logic cmd, logic signed [tsld_pkg::SAMPLE_W-1:0] sample);
        t_demod_item it;
        it.cmd    = cmd;
        it.sample = sample;
        pending_items.push_back(it);
    endtask

    // Hold off until every queued transaction went out and every result came back
    task automatic drain_all();
        while (pending_items.size() != 0 || drv_valid || expected_sums.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Bin writes only while the pipeline is empty
    task automatic write_bin(logic [tsld_pkg::BIN_W-1:0] v);
        drain_all();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [tsld_pkg::SAMPLE_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh7FFF;
        if (r == 1) return 16'sh8000;
        return tsld_pkg::SAMPLE_W'($urandom());
    endfunction

    // Random accumulate traffic with occasional clears; the sender pauses
    // halfway until every result is back.
    task automatic run_random_phase(logic [tsld_pkg::BIN_W-1:0] bin, int count);
        write_bin(bin);
        idle_off = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) drain_all();
            queue_item(($urandom_range(0, 19) == 0) ? tsld_pkg::CMD_CLEAR
                                                    : tsld_pkg::CMD_ACCUM,
                       random_sample());
        end
    endtask

    //--------------------------------------------------------------------------
    // Watchdog
    //--------------------------------------------------------------------------
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    //--------------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------------
    initial begin : sequence_main
        logic [tsld_pkg::BIN_W-1:0] phase_bins[RANDOM_PHASES];
        phase_bins = '{8'd1, 8'd255, 8'd128, 8'd3, 8'd192, 8'd2, 8'd0,
                       tsld_pkg::BIN_W'($urandom()), tsld_pkg::BIN_W'($urandom()),
                       tsld_pkg::BIN_W'($urandom())};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset bin of 1: sample extremes, then a clear carrying a nonzero
        // sample that must be ignored.
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh7FFF);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh8000);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh0000);
        queue_item(tsld_pkg::CMD_ACCUM, -16'sd1);
        queue_item(tsld_pkg::CMD_CLEAR, 16'sh8000);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sd1);

        // Quarter-table step: every angle is a zero crossing of one reference
        write_bin(8'd64);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh7FFF);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh8000);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh7FFF);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh8000);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh5555);
        queue_item(tsld_pkg::CMD_CLEAR, 16'sh7FFF);
        queue_item(tsld_pkg::CMD_ACCUM, -16'sh5556);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sd1);

        // Bin of zero: angle pinned at 0, in-phase +1, quadrature 0
        write_bin(8'd0);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh7FFF);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh8000);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sd12345);
        queue_item(tsld_pkg::CMD_CLEAR, 16'sd12345);

        // Largest bin
        write_bin(8'd255);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh7FFF);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sh8000);
        queue_item(tsld_pkg::CMD_ACCUM, -16'sd2);
        queue_item(tsld_pkg::CMD_ACCUM, 16'sd2);

        // Back-to-back run: with a quarter-table step this pattern adds 65535
        // to both sums every four samples.
        write_bin(8'd64);
        idle_off = 1'b1;
        for (int p = 0; p < WRAP_PERIODS; p++) begin
            queue_item(tsld_pkg::CMD_ACCUM, 16'sh7FFF);
            queue_item(tsld_pkg::CMD_ACCUM, 16'sh8000);
            queue_item(tsld_pkg::CMD_ACCUM, 16'sh8000);
            queue_item(tsld_pkg::CMD_ACCUM, 16'sh7FFF);
        end

        foreach (phase_bins[k]) run_random_phase(phase_bins[k], PHASE_ITEMS);

        drain_all();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
